// File: hw/rtl/sliding_window_maximum_macros.svh
// Assertion macros for the sliding window maximum block.
`ifndef SLIDING_WINDOW_MAXIMUM_MACROS_SVH
`define SLIDING_WINDOW_MAXIMUM_MACROS_SVH

`ifndef SYNTHESIS

// Check an invariant at every clock edge outside reset.
`define SWM_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant violated");

// Check that a trigger is followed by an outcome in the next cycle.
`define SWM_ASSERT_NEXT(label, clk, rst, trig, outcome) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (outcome)) \
      else $error("next-cycle check violated");

`else

`define SWM_ASSERT_ALWAYS(label, clk, rst, cond)
`define SWM_ASSERT_NEXT(label, clk, rst, trig, outcome)

`endif

`endif

// File: hw/rtl/swm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

   localparam int MAX_WINDOW_DEFAULT   = 64;
   localparam int SAMPLE_WIDTH_DEFAULT = 16;
   localparam int CSR_WIDTH            = 7;

   localparam logic [CSR_WIDTH-1:0] WINDOW_SIZE_RESET = CSR_WIDTH'(1);

endpackage

`default_nettype wire

// File: hw/rtl/swm_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One stage of the running-max chain: holds the maximum of the last k+1 samples
// for its place k in the row.
module swm_cell
   import swm_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           shift_en,
   input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
   input  wire logic signed [SAMPLE_WIDTH-1:0] left_value,
   output logic signed [SAMPLE_WIDTH-1:0]      value,
   output logic signed [SAMPLE_WIDTH-1:0]      next_value
);

   logic signed [SAMPLE_WIDTH-1:0] value_ff;
   logic signed [SAMPLE_WIDTH-1:0] value_in;

   // max of the new sample and the neighbor's span one shorter
   always_comb begin
      value_in = (sample > left_value) ? sample : left_value;
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         value_ff <= value_in;
      end
   end

   assign value      = value_ff;
   assign next_value = value_in;

endmodule

`default_nettype wire

// File: hw/rtl/sliding_window_maximum.sv
// Running maximum over the last window_size signed samples. A row of
// MAX_WINDOW cells keeps, in cell k, the maximum of the last k+1 samples; each
// accepted item moves every cell's value one place along the row, merged with
// the new sample by one compare per cell. The block takes one item per clock
// while not stalled; its result, when the current sequence holds at least
// window_size samples, sits in the output register in the cycle after
// acceptance and stays there until taken. The input side stalls only while a
// result waits and rsp_ready is low. req_start_req begins a new sequence with
// its own sample. window_size of zero acts as one and values above MAX_WINDOW
// act as MAX_WINDOW; a new size applies from the next item on.
`timescale 1ns / 1ps
`default_nettype none

`include "sliding_window_maximum_macros.svh"

module sliding_window_maximum
   import swm_pkg::*;
#(
   parameter int MAX_WINDOW   = MAX_WINDOW_DEFAULT,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  wire logic                           req_start_req,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_window_max,
   input  wire logic                           csr_write_enable,
   input  wire logic [CSR_WIDTH-1:0]           csr_write_data
);

   localparam int WIN_W = $clog2(MAX_WINDOW + 1);
   localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN =
      {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   logic [CSR_WIDTH-1:0]           window_size_ff;
   logic [WIN_W-1:0]               filled_ff;
   logic [WIN_W-1:0]               filled_in;
   logic [WIN_W-1:0]               fill_base;
   logic [WIN_W-1:0]               win_eff;
   logic [IDX_W-1:0]               out_sel;
   logic                           rsp_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] rsp_window_max_ff;
   logic                           accept;
   logic                           give_result;

   logic signed [SAMPLE_WIDTH-1:0] cell_value [MAX_WINDOW];
   logic signed [SAMPLE_WIDTH-1:0] cell_next  [MAX_WINDOW];

   assign req_ready      = !rsp_valid_ff || rsp_ready;
   assign accept         = req_valid && req_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_window_max = rsp_window_max_ff;

   // zero acts as one; clamp sizes beyond the row length
   always_comb begin
      if (window_size_ff == '0) begin
         win_eff = WIN_W'(1);
      end else if (32'(window_size_ff) > 32'(MAX_WINDOW)) begin
         win_eff = WIN_W'(MAX_WINDOW);
      end else begin
         win_eff = WIN_W'(window_size_ff);
      end
      out_sel = IDX_W'(win_eff - WIN_W'(1));
   end

   // samples in the current sequence, saturating at the window size
   always_comb begin
      fill_base = req_start_req ? '0 : filled_ff;
      if (fill_base > win_eff) begin
         fill_base = win_eff;
      end
      if (fill_base < win_eff) begin
         filled_in = fill_base + WIN_W'(1);
      end else begin
         filled_in = fill_base;
      end
      give_result = (filled_in == win_eff);
   end

   for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
      logic signed [SAMPLE_WIDTH-1:0] left_value;

      if (k == 0) begin : g_head
         assign left_value = SAMPLE_MIN;
      end else begin : g_body
         assign left_value = cell_value[k-1];
      end

      swm_cell #(
         .SAMPLE_WIDTH(SAMPLE_WIDTH)
      ) u_cell (
         .clock     (clock),
         .shift_en  (accept),
         .sample    (req_sample),
         .left_value(left_value),
         .value     (cell_value[k]),
         .next_value(cell_next[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WINDOW_SIZE_RESET;
         filled_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            window_size_ff <= csr_write_data;
         end
         if (accept) begin
            filled_ff    <= filled_in;
            rsp_valid_ff <= give_result;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // hold the result until taken
   always_ff @(posedge clock) begin
      if (accept && give_result) begin
         rsp_window_max_ff <= cell_next[out_sel];
      end
   end

   `SWM_ASSERT_ALWAYS(a_fill_bounded, clock, reset, 32'(filled_ff) <= MAX_WINDOW)
   `SWM_ASSERT_NEXT(a_start_restarts, clock, reset, accept && req_start_req && win_eff > WIN_W'(1), filled_ff == WIN_W'(1) && !rsp_valid)
   `SWM_ASSERT_NEXT(a_full_gives_result, clock, reset, accept && give_result, rsp_valid)
   `SWM_ASSERT_NEXT(a_head_cell_loads, clock, reset, accept, cell_value[0] == $past(req_sample))

endmodule

`default_nettype wire
